>>> design/sine_tone_alaw_generator_macros.svh
// ----------------------------------------------------------------------------
// Sine tone A-law generator assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef SINE_TONE_ALAW_GENERATOR_MACROS_SVH
`define SINE_TONE_ALAW_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sta_pkg.sv
// ----------------------------------------------------------------------------
// Sine tone A-law generator package
// Request and response payloads, pipeline control, A-law constants and the
// fixed-point quarter-wave sine function used to build the sine ROM.
// ----------------------------------------------------------------------------
package sta_pkg;

	// Request payload: one amplitude byte and the end-of-buffer flag.
	typedef struct packed {
		logic [7:0] amplitude;
		logic       last_of_buffer;
	} sta_in_t;

	// Response payload: one A-law byte and the copied flag.
	typedef struct packed {
		logic [7:0] alaw_code;
		logic       last_sample;
	} sta_out_t;

	// Stage moves: a request taken into stage 1, and data moving on
	// from stage 1, 2 and 3 into the following register.
	typedef struct packed {
		logic acc;
		logic mv1;
		logic mv2;
		logic mv3;
	} sta_ctl_t;

	localparam int unsigned STEP_W   = 32;
	localparam int unsigned SINE_W   = 15;
	localparam int unsigned AMP_W    = 8;
	localparam int unsigned PROD_W   = SINE_W + AMP_W;
	localparam int unsigned MAG_W    = 12;

	// Rounding offset and reciprocal of 255 (ceil(2^31 / 255)).
	localparam logic [PROD_W-1:0] ROUND_255  = PROD_W'(127);
	localparam logic [23:0]       RECIP_255  = 24'd8421505;
	localparam int unsigned       RECIP_SHFT = 31;

	localparam logic [7:0] ALAW_MASK_POS = 8'hD5;
	localparam logic [7:0] ALAW_MASK_NEG = 8'h55;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_Q30    = 64'd536870912;

	// Sine of quarter-wave index q, scaled to 0..32767, from a Q30 Taylor
	// series up to the thirteenth power. Evaluated at elaboration only.
	function automatic logic [SINE_W-1:0] quarter_sine(input int unsigned q,
		input int unsigned addr_bits);
		logic [63:0]    x;
		logic [63:0]    x2;
		logic [63:0]    term;
		logic [63:0]    res;
		longint         sum;
		x    = (64'(q) * HALF_PI_Q30 + (64'd1 << (addr_bits - 3))) >> (addr_bits - 2);
		x2   = (x * x + HALF_Q30) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2 + HALF_Q30) >> 30) / 64'd6;
		sum  = sum - longint'(term);
		term = ((term * x2 + HALF_Q30) >> 30) / 64'd20;
		sum  = sum + longint'(term);
		term = ((term * x2 + HALF_Q30) >> 30) / 64'd42;
		sum  = sum - longint'(term);
		term = ((term * x2 + HALF_Q30) >> 30) / 64'd72;
		sum  = sum + longint'(term);
		term = ((term * x2 + HALF_Q30) >> 30) / 64'd110;
		sum  = sum - longint'(term);
		term = ((term * x2 + HALF_Q30) >> 30) / 64'd156;
		sum  = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		res = (64'(sum) * 64'd32767 + HALF_Q30) >> 30;
		return res[SINE_W-1:0];
	endfunction

endpackage

>>> design/sta_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// Pipeline flow control
// Valid bits of the four stages and the per-stage moves; each stage loads
// whenever it is empty or its contents are moving on.
// ----------------------------------------------------------------------------
module sta_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output sta_pkg::sta_ctl_t ctl
);
	import sta_pkg::*;

	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic out_valid_q;
	logic load_out;
	logic load3;
	logic load2;
	logic load1;

	// Back-pressure chain from the output register towards the request side.
	always_comb begin
		load_out  = !out_valid_q || rsp_ready;
		ctl.mv3   = v_s3 && load_out;
		load3     = !v_s3 || ctl.mv3;
		ctl.mv2   = v_s2 && load3;
		load2     = !v_s2 || ctl.mv2;
		ctl.mv1   = v_s1 && load2;
		load1     = !v_s1 || ctl.mv1;
		req_ready = load1;
		ctl.acc   = req_valid && load1;
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load1) begin
				v_s1 <= ctl.acc;
			end
			if (load2) begin
				v_s2 <= v_s1;
			end
			if (load3) begin
				v_s3 <= v_s2;
			end
			if (load_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> design/sta_phase_gen.sv
// ----------------------------------------------------------------------------
// Phase generator
// Holds the phase step register and the phase accumulator, turns the top of
// the phase into a quarter-wave ROM index and registers the request fields.
// ----------------------------------------------------------------------------
module sta_phase_gen #(
	parameter int unsigned PHASE_BITS     = 32,
	parameter int unsigned SINE_ADDR_BITS = 10
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [sta_pkg::STEP_W-1:0]   cfg_data,
	input  sta_pkg::sta_ctl_t            ctl,
	input  sta_pkg::sta_in_t             req_data,
	output logic [SINE_ADDR_BITS-2:0]    rom_idx,
	output logic [sta_pkg::AMP_W-1:0]    amp_s1,
	output logic                         neg_s1,
	output logic                         last_s1
);
	import sta_pkg::*;

	localparam int unsigned QW        = SINE_ADDR_BITS - 1;
	localparam int unsigned QUARTER_N = 2 ** (SINE_ADDR_BITS - 2);

	logic [STEP_W-1:0]         phase_step_q;
	logic [PHASE_BITS-1:0]     phase_accum_q;
	logic [PHASE_BITS-1:0]     step_ext;
	logic [SINE_ADDR_BITS-1:0] addr;
	logic [SINE_ADDR_BITS-3:0] offs;

	// The step is masked or widened to the accumulator width.
	assign step_ext = PHASE_BITS'(phase_step_q);

	// Quadrant decode: odd quadrants run the quarter table backwards.
	always_comb begin
		addr = phase_accum_q[PHASE_BITS-1 -: SINE_ADDR_BITS];
		offs = addr[SINE_ADDR_BITS-3:0];
		if (addr[SINE_ADDR_BITS-2]) begin
			rom_idx = QW'(QUARTER_N) - QW'(offs);
		end else begin
			rom_idx = QW'(offs);
		end
	end

	// Configuration register and phase accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q  <= '0;
			phase_accum_q <= '0;
		end else begin
			if (cfg_valid) begin
				phase_step_q <= cfg_data;
			end
			if (ctl.acc) begin
				phase_accum_q <= phase_accum_q + step_ext;
			end
		end
	end

	// Stage 1 side fields, loaded with the ROM read.
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			amp_s1  <= req_data.amplitude;
			neg_s1  <= addr[SINE_ADDR_BITS-1];
			last_s1 <= req_data.last_of_buffer;
		end
	end

endmodule

>>> design/sta_sine_rom.sv
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Magnitudes of the sine over the first quarter period, end points included,
// built at elaboration and read with a registered output.
// ----------------------------------------------------------------------------
module sta_sine_rom #(
	parameter int unsigned SINE_ADDR_BITS = 10
) (
	input  logic                         clk,
	input  sta_pkg::sta_ctl_t            ctl,
	input  logic [SINE_ADDR_BITS-2:0]    rom_idx,
	output logic [sta_pkg::SINE_W-1:0]   mag_s1
);
	import sta_pkg::*;

	localparam int unsigned ROM_DEPTH = 2 ** (SINE_ADDR_BITS - 2) + 1;

	typedef logic [SINE_W-1:0] rom_t [ROM_DEPTH];

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			t[i] = quarter_sine(i, SINE_ADDR_BITS);
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// Registered read, taken with each accepted request.
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			mag_s1 <= SINE_ROM[rom_idx];
		end
	end

endmodule

>>> design/sta_scaler.sv
// ----------------------------------------------------------------------------
// Amplitude scaler
// Multiplies the sine magnitude by the amplitude and divides by 255 with
// rounding, using a reciprocal multiplication in the following stage.
// ----------------------------------------------------------------------------
module sta_scaler (
	input  logic                        clk,
	input  sta_pkg::sta_ctl_t           ctl,
	input  logic [sta_pkg::SINE_W-1:0]  mag_s1,
	input  logic [sta_pkg::AMP_W-1:0]   amp_s1,
	input  logic                        neg_s1,
	input  logic                        last_s1,
	output logic [sta_pkg::SINE_W-1:0]  quot_s3,
	output logic                        neg_s3,
	output logic                        last_s3
);
	import sta_pkg::*;

	logic [PROD_W-1:0]      prod_s2;
	logic                   neg_s2;
	logic                   last_s2;
	logic [PROD_W+23:0]     recip_prod;

	// Stage 2: magnitude times amplitude plus half of 255.
	always_ff @(posedge clk) begin
		if (ctl.mv1) begin
			prod_s2 <= PROD_W'(mag_s1) * PROD_W'(amp_s1) + ROUND_255;
			neg_s2  <= neg_s1;
			last_s2 <= last_s1;
		end
	end

	// Stage 3: the reciprocal product is exact for every sum below 2^23.
	assign recip_prod = (PROD_W + 24)'(prod_s2) * (PROD_W + 24)'(RECIP_255);

	always_ff @(posedge clk) begin
		if (ctl.mv2) begin
			quot_s3 <= recip_prod[RECIP_SHFT +: SINE_W];
			neg_s3  <= neg_s2;
			last_s3 <= last_s2;
		end
	end

endmodule

>>> design/sta_alaw_enc.sv
// ----------------------------------------------------------------------------
// A-law encoder
// Encodes the signed scaled sample as a G.711 A-law byte into the output
// register.
// ----------------------------------------------------------------------------
module sta_alaw_enc (
	input  logic                        clk,
	input  sta_pkg::sta_ctl_t           ctl,
	input  logic [sta_pkg::SINE_W-1:0]  quot_s3,
	input  logic                        neg_s3,
	input  logic                        last_s3,
	output sta_pkg::sta_out_t           rsp_data
);
	import sta_pkg::*;

	logic              is_neg;
	logic [SINE_W:0]   biased;
	logic [MAG_W-1:0]  mag;
	logic [2:0]        seg;
	logic [MAG_W-1:0]  shifted;
	logic [3:0]        mant;
	logic [7:0]        code;
	sta_out_t          rsp_q;

	// A zero result counts as positive whatever the quadrant.
	assign is_neg = neg_s3 && (quot_s3 != '0);

	// Fifteen-bit scaled sample folded to its twelve-bit magnitude, then segment and mantissa.
	always_comb begin
		biased = {1'b0, quot_s3} + (SINE_W + 1)'(7);
		if (is_neg) begin
			mag = biased[MAG_W+2:3] - MAG_W'(1);
		end else begin
			mag = quot_s3[MAG_W+2:3];
		end
		seg = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (mag[i + 4]) begin
				seg = 3'(i);
			end
		end
		if (seg < 3'd2) begin
			shifted = mag >> 1;
		end else begin
			shifted = mag >> seg;
		end
		mant = shifted[3:0];
		code = {1'b0, seg, mant} ^ (is_neg ? ALAW_MASK_NEG : ALAW_MASK_POS);
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (ctl.mv3) begin
			rsp_q.alaw_code   <= code;
			rsp_q.last_sample <= last_s3;
		end
	end

	assign rsp_data = rsp_q;

endmodule

>>> design/sine_tone_alaw_generator.sv
// ----------------------------------------------------------------------------
// Sine tone A-law generator
// Numerically controlled sine oscillator with amplitude scaling and G.711
// A-law output, one code byte per amplitude request.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_ready, req_data) carries one amplitude
// byte per sample, 255 being full scale, and an end-of-buffer flag. Each
// request gives exactly one response on rsp_valid, rsp_ready, rsp_data: the
// A-law code of the sine at the current phase scaled by amplitude/255, with
// the flag copied. The phase then advances by the phase step.
// The phase step is written on the cfg channel (cfg_valid, cfg_ready,
// cfg_data); cfg_ready is always high and the step should only be changed
// while no request is in flight.
// A request taken is registered in stage 1 (ROM read and side fields), then in
// stage 2 (product), stage 3 (quotient) and the output register. Throughput is
// one request per cycle while the receiver keeps up, set by the single accumulator
// add and the one ROM read per request. Reset clears the phase accumulator,
// the phase step and all stage valid bits. When the receiver stalls, the four
// stages fill up and req_ready falls only once every stage holds a request.
// ----------------------------------------------------------------------------
module sine_tone_alaw_generator #(
	parameter int unsigned PHASE_BITS     = 32,
	parameter int unsigned SINE_ADDR_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_ready,
	input  sta_pkg::sta_in_t           req_data,
	output logic                       rsp_valid,
	input  logic                       rsp_ready,
	output sta_pkg::sta_out_t          rsp_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sta_pkg::STEP_W-1:0] cfg_data
);
	import sta_pkg::*;

	sta_ctl_t                  ctl;
	logic [SINE_ADDR_BITS-2:0] rom_idx;
	logic [SINE_W-1:0]         mag_s1;
	logic [AMP_W-1:0]          amp_s1;
	logic                      neg_s1;
	logic                      last_s1;
	logic [SINE_W-1:0]         quot_s3;
	logic                      neg_s3;
	logic                      last_s3;

	// The step register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	sta_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.ctl       (ctl)
	);

	sta_phase_gen #(
		.PHASE_BITS     (PHASE_BITS),
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.ctl       (ctl),
		.req_data  (req_data),
		.rom_idx   (rom_idx),
		.amp_s1    (amp_s1),
		.neg_s1    (neg_s1),
		.last_s1   (last_s1)
	);

	sta_sine_rom #(
		.SINE_ADDR_BITS (SINE_ADDR_BITS)
	) u_rom (
		.clk     (clk),
		.ctl     (ctl),
		.rom_idx (rom_idx),
		.mag_s1  (mag_s1)
	);

	sta_scaler u_scale (
		.clk     (clk),
		.ctl     (ctl),
		.mag_s1  (mag_s1),
		.amp_s1  (amp_s1),
		.neg_s1  (neg_s1),
		.last_s1 (last_s1),
		.quot_s3 (quot_s3),
		.neg_s3  (neg_s3),
		.last_s3 (last_s3)
	);

	sta_alaw_enc u_enc (
		.clk      (clk),
		.ctl      (ctl),
		.quot_s3  (quot_s3),
		.neg_s3   (neg_s3),
		.last_s3  (last_s3),
		.rsp_data (rsp_data)
	);

endmodule

>>> design/sta_checker.sv
// ----------------------------------------------------------------------------
// Sine tone A-law generator port checker
// Watches the top-level ports: no response without an outstanding request,
// bounded fill, an empty block accepts, and stalled responses hold.
// ----------------------------------------------------------------------------
`include "sine_tone_alaw_generator_macros.svh"

module sta_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input sta_pkg::sta_out_t          rsp_data,
	input logic                       cfg_ready
);
	import sta_pkg::*;

	logic [2:0] pending_q;
	logic       req_take;
	logic       rsp_take;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;

	// Requests accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(req_take) - 3'(rsp_take);
		end
	end

	`STA_ASSERT_NOW(a_no_invented_rsp, rsp_valid, pending_q != 3'd0, "response without request")
	`STA_ASSERT_NOW(a_fill_bound, 1'b1, pending_q <= 3'd4, "more requests in flight than stages")
	`STA_ASSERT_NOW(a_empty_accepts, pending_q == 3'd0, req_ready && cfg_ready, "idle block not ready")
	`STA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled response changed")

endmodule

bind sine_tone_alaw_generator sta_checker u_sta_checker (.*);
